/* rtl/bdfe_pkg.sv */
package bdfe_pkg;

   localparam logic [7:0] OPEN_BRACE  = 8'h7B;
   localparam logic [7:0] CLOSE_BRACE = 8'h7D;

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } bdfe_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } bdfe_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic take;    // request transaction accepted this cycle
      logic rd_en;   // read next stored byte into the response register
   } bdfe_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic frame_done;  // accepted byte closes the outermost brace
      logic rd_last;     // current read pointer is the final frame byte
   } bdfe_status_type;

endpackage

/* rtl/bdfe_datapath.sv */
module bdfe_datapath #(
   parameter int FRAME_SIZE = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   input  bdfe_pkg::bdfe_req_type   req_data,
   input  bdfe_pkg::bdfe_cmd_type   cmd,
   output bdfe_pkg::bdfe_status_type status,
   output bdfe_pkg::bdfe_rsp_type   rsp_data
);
   import bdfe_pkg::*;

   localparam int              IDX_W    = $clog2(FRAME_SIZE);
   localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(FRAME_SIZE - 1);
   localparam logic [IDX_W-1:0] ONE      = IDX_W'(1);
   localparam logic [IDX_W-1:0] ZERO     = '0;

   logic [7:0]       store_mem [FRAME_SIZE];

   logic             enable_ff;
   logic             enable_in;
   logic [IDX_W-1:0] fill_ff;
   logic [IDX_W-1:0] fill_in;
   logic [IDX_W-1:0] depth_ff;
   logic [IDX_W-1:0] depth_in;
   logic [IDX_W-1:0] last_idx_ff;
   logic [IDX_W-1:0] last_idx_in;
   logic [IDX_W-1:0] ptr_ff;
   logic [IDX_W-1:0] ptr_in;
   logic [7:0]       rd_byte_ff;
   logic             rd_last_ff;

   logic             byte_go;
   logic             is_open;
   logic             is_close;
   logic [IDX_W-1:0] depth_dec;
   logic             frame_done;

   assign is_open   = (req_data.rx_byte == OPEN_BRACE);
   assign is_close  = (req_data.rx_byte == CLOSE_BRACE);
   assign depth_dec = depth_ff - ONE;

   assign byte_go = cmd.take && (req_data.command == CMD_BYTE) && enable_ff
                    && (fill_ff != FULL_IDX) && !((fill_ff == ZERO) && !is_open);

   assign frame_done = byte_go && is_close && (depth_dec == ZERO);

   always_comb begin
      enable_in   = csr_write_enable ? csr_write_data : enable_ff;
      fill_in     = fill_ff;
      depth_in    = depth_ff;
      last_idx_in = last_idx_ff;
      ptr_in      = ptr_ff;

      if (cmd.take) begin
         if (req_data.command == CMD_FLUSH) begin
            fill_in  = ZERO;
            depth_in = ZERO;
         end else if (enable_ff && (fill_ff == FULL_IDX)) begin
            fill_in  = ZERO;
            depth_in = ZERO;
         end else if (byte_go) begin
            if (frame_done) begin
               fill_in     = ZERO;
               depth_in    = ZERO;
               last_idx_in = fill_ff;
               ptr_in      = ZERO;
            end else begin
               fill_in = fill_ff + ONE;
               if (is_open) begin
                  depth_in = depth_ff + ONE;
               end else if (is_close) begin
                  depth_in = depth_dec;
               end
            end
         end
      end

      if (cmd.rd_en) begin
         ptr_in = ptr_ff + ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         fill_ff   <= ZERO;
         depth_ff  <= ZERO;
      end else begin
         enable_ff <= enable_in;
         fill_ff   <= fill_in;
         depth_ff  <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff <= last_idx_in;
      ptr_ff      <= ptr_in;
   end

   always_ff @(posedge clock) begin
      if (byte_go) begin
         store_mem[fill_ff] <= req_data.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_byte_ff <= store_mem[ptr_ff];
         rd_last_ff <= (ptr_ff == last_idx_ff);
      end
   end

   assign status.frame_done = frame_done;
   assign status.rd_last    = (ptr_ff == last_idx_ff);

   assign rsp_data.frame_byte = rd_byte_ff;
   assign rsp_data.last_byte  = rd_last_ff;

`ifndef SYNTHESIS
   a_depth_le_fill : assert property (@(posedge clock) disable iff (reset)
      depth_ff <= fill_ff)
      else $error("brace depth exceeds fill count");

   a_done_nonempty : assert property (@(posedge clock) disable iff (reset)
      frame_done |-> (fill_ff != ZERO) && (depth_ff == ONE))
      else $error("frame closed without open frame");

   a_read_in_frame : assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (ptr_ff <= last_idx_ff))
      else $error("read past end of frame");
`endif

endmodule

/* rtl/bdfe_ctrl.sv */
module bdfe_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  bdfe_pkg::bdfe_status_type status,
   output bdfe_pkg::bdfe_cmd_type    cmd
);
   import bdfe_pkg::*;

   typedef enum logic {
      ST_ACCEPT,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      req_stall = (state_ff == ST_EMIT);
      cmd.take  = req_valid && !req_stall;
      cmd.rd_en = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

      state_in = state_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (cmd.take && status.frame_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.rd_en && status.rd_last) begin
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase

      if (cmd.rd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_done_to_emit : assert property (@(posedge clock) disable iff (reset)
      cmd.take && status.frame_done |=> (state_ff == ST_EMIT))
      else $error("completed frame did not start emission");

   a_no_take_in_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !cmd.take)
      else $error("request accepted during emission");

   a_rsp_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("stalled response dropped");
`endif

endmodule

/* rtl/brace_depth_frame_extractor_core.sv */
// Request transaction: accepted while no frame is being emitted. A closing brace
// that completes an n-byte frame (n <= FRAME_SIZE-1) holds off requests while
// the store is read out through the response register, one byte per cycle;
// response stalls pause the readout. The first byte is valid after the state
// and then the response register load. Reset is synchronous, active high: clears
// fill count, depth and controller state, sets enable; store is not cleared.
module brace_depth_frame_extractor_core #(
   parameter int FRAME_SIZE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bdfe_pkg::bdfe_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bdfe_pkg::bdfe_rsp_type rsp_data
);
   import bdfe_pkg::*;

   bdfe_cmd_type    cmd;
   bdfe_status_type status;

   bdfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bdfe_datapath #(
      .FRAME_SIZE (FRAME_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

endmodule

/* verif/frame_check_pkg.sv */
`timescale 1ns / 100ps

package frame_check_pkg;

   import bdfe_pkg::*;

   class frame_scoreboard;
      localparam int FRAME_SIZE = 64;

      logic [7:0]   frame_store [FRAME_SIZE];
      logic [5:0]   fill_count;
      logic [5:0]   brace_depth;
      logic         accept_enable;
      bdfe_rsp_type frame_bytes_due[$];
      int           errors;

      function new();
         fill_count    = '0;
         brace_depth   = '0;
         accept_enable = 1'b1;
         errors        = 0;
      endfunction

      function int pending();
         return frame_bytes_due.size();
      endfunction

      // predicts the frame bytes released by one accepted request transaction
      function void note_request(bdfe_req_type item);
         int           count;
         bdfe_rsp_type out_byte;
         if (item.command == CMD_FLUSH) begin
            fill_count  = '0;
            brace_depth = '0;
            return;
         end
         if (!accept_enable) return;
         if (fill_count >= FRAME_SIZE - 1) begin
            fill_count  = '0;
            brace_depth = '0;
            return;
         end
         if (fill_count == 0 && item.rx_byte != OPEN_BRACE) return;
         frame_store[fill_count] = item.rx_byte;
         fill_count = fill_count + 6'd1;
         if (item.rx_byte == OPEN_BRACE) begin
            brace_depth = brace_depth + 6'd1;
            return;
         end
         if (item.rx_byte != CLOSE_BRACE) return;
         brace_depth = brace_depth - 6'd1;
         if (brace_depth != 0) return;
         count = fill_count;
         for (int k = 0; k < count; k++) begin
            out_byte.frame_byte = frame_store[k];
            out_byte.last_byte  = (k == count - 1);
            frame_bytes_due.push_back(out_byte);
         end
         fill_count  = '0;
         brace_depth = '0;
      endfunction

      function void check_response(bdfe_rsp_type actual);
         bdfe_rsp_type predicted;
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected response: frame_byte %h last_byte %b",
                   actual.frame_byte, actual.last_byte);
            errors++;
            return;
         end
         predicted = frame_bytes_due.pop_front();
         if (actual.frame_byte !== predicted.frame_byte) begin
            $error("frame_byte: expected %h, actual %h",
                   predicted.frame_byte, actual.frame_byte);
            errors++;
         end
         if (actual.last_byte !== predicted.last_byte) begin
            $error("last_byte: expected %b, actual %b",
                   predicted.last_byte, actual.last_byte);
            errors++;
         end
      endfunction
   endclass

endpackage

/* verif/tb_brace_depth_frame_extractor_core.sv */
`timescale 1ns / 100ps

module tb_brace_depth_frame_extractor_core;

   import bdfe_pkg::*;
   import frame_check_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 70;

   logic         clock;
   logic         reset;
   logic         csr_write_enable;
   logic         csr_write_data;
   logic         req_valid;
   logic         req_stall;
   bdfe_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   bdfe_rsp_type rsp_data;

   frame_scoreboard sb = new();
   bdfe_req_type    byte_seq[$];
   int              send_idle_pct;
   int              rsp_stall_pct;
   int              hold_left;
   int              cycles;

   brace_depth_frame_extractor_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
      end
   end

   // receiver; a requested hold-off is counted down here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
      end
   end

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == OPEN_BRACE || b == CLOSE_BRACE) b = b ^ 8'h80;
      return b;
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      bdfe_req_type item;
      item.command = CMD_BYTE;
      item.rx_byte = b;
      byte_seq.push_back(item);
   endfunction

   function automatic void push_flush(input logic [7:0] b);
      bdfe_req_type item;
      item.command = CMD_FLUSH;
      item.rx_byte = b;
      byte_seq.push_back(item);
   endfunction

   // brace-balanced frame of at most len bytes
   function automatic void push_frame(input int len);
      int depth;
      int n;
      int rem;
      int r;
      push_byte(OPEN_BRACE);
      depth = 1;
      n     = 1;
      while (depth > 0) begin
         rem = len - n;
         r   = $urandom_range(9);
         if (rem <= depth) begin
            push_byte(CLOSE_BRACE);
            depth--;
         end else if (r < 2 && rem > depth + 1) begin
            push_byte(OPEN_BRACE);
            depth++;
         end else if (r < 4 && depth > 1) begin
            push_byte(CLOSE_BRACE);
            depth--;
         end else begin
            push_byte(plain_byte());
         end
         n++;
      end
   endfunction

   // fills the store, then one more byte is dropped
   function automatic void push_overflow();
      push_byte(OPEN_BRACE);
      repeat (62) push_byte(plain_byte());
      push_byte(8'($urandom_range(255)));
   endfunction

   function automatic int push_random_sequence();
      int pick;
      int start;
      int k;
      pick  = $urandom_range(99);
      start = byte_seq.size();
      if (pick < 72) begin
         push_frame(($urandom_range(15) == 0) ? $urandom_range(13, 63) : $urandom_range(2, 12));
      end else if (pick < 75) begin
         push_overflow();
      end else if (pick < 78) begin
         push_frame(63);
      end else if (pick < 88) begin
         push_byte(OPEN_BRACE);
         k = $urandom_range(0, 6);
         repeat (k) push_byte($urandom_range(1) ? plain_byte() : OPEN_BRACE);
         push_flush(8'($urandom_range(255)));
      end else begin
         k = $urandom_range(1, 3);
         repeat (k) begin
            if ($urandom_range(3) == 0) push_flush(8'($urandom_range(255)));
            else push_byte(8'($urandom_range(255)));
         end
      end
      return byte_seq.size() - start;
   endfunction

   task automatic send_request(input bdfe_req_type item);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_sequence();
      foreach (byte_seq[i]) send_request(byte_seq[i]);
      byte_seq.delete();
   endtask

   task automatic run_items(input int target);
      int sent;
      sent = 0;
      while (sent < target) begin
         sent += push_random_sequence();
         send_sequence();
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_enable(input logic value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.accept_enable = value;
      @(negedge clock);
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_stall        = 1'b0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      hold_left        = 0;
      cycles           = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_enable(1'b1);

      // idle bytes are skipped, then simple and nested frames
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CLOSE_BRACE);
      push_byte(OPEN_BRACE);
      push_byte(CLOSE_BRACE);
      push_byte(OPEN_BRACE);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(OPEN_BRACE);
      push_byte(CLOSE_BRACE);
      push_byte(CLOSE_BRACE);
      // flush mid-frame
      push_byte(OPEN_BRACE);
      push_byte(8'h35);
      push_flush(8'hFF);
      push_byte(CLOSE_BRACE);
      push_byte(OPEN_BRACE);
      push_byte(8'h61);
      send_sequence();

      // disabled bytes leave the partial frame intact
      set_enable(1'b0);
      push_byte(CLOSE_BRACE);
      push_byte(8'h62);
      send_sequence();
      set_enable(1'b1);
      push_byte(CLOSE_BRACE);
      push_byte(OPEN_BRACE);
      send_sequence();

      // flush while disabled still clears
      set_enable(1'b0);
      push_flush(8'h00);
      send_sequence();
      set_enable(1'b1);
      push_byte(CLOSE_BRACE);
      push_byte(OPEN_BRACE);
      push_byte(CLOSE_BRACE);
      send_sequence();

      push_overflow();
      push_frame(63);
      send_sequence();
      run_items(12);

      send_idle_pct = 80;
      run_items(10);

      set_enable(1'b0);
      run_items(6);
      set_enable(1'b1);

      send_idle_pct = 0;
      rsp_stall_pct = 80;
      run_items(12);

      send_idle_pct = 38;
      rsp_stall_pct = 38;
      run_items(12);

      // long receiver hold-off while requests keep coming
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left     = HOLD_CYCLES;
      run_items(10);

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

/* brace_depth_frame_extractor_core.f */
rtl/bdfe_pkg.sv
rtl/bdfe_datapath.sv
rtl/bdfe_ctrl.sv
rtl/brace_depth_frame_extractor_core.sv
verif/frame_check_pkg.sv
verif/tb_brace_depth_frame_extractor_core.sv
